// ----- rtl/core/vog_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vog_pkg;

  // Field widths fixed by the register map
  localparam int RES_W     = 16;
  localparam int SIZE_XY_W = 7;
  localparam int SIZE_Z_W  = 5;
  localparam int CFG_IDX_W = 3;

  // Occupancy codes
  localparam logic [1:0] OCC_UNMAPPED = 2'd0;
  localparam logic [1:0] OCC_EMPTY    = 2'd1;
  localparam logic [1:0] OCC_OCCUPIED = 2'd2;
  localparam logic [1:0] OCC_OOB      = 2'd3;

  // Request codes
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z     = 3'd6;

  // Commands from the controller to the datapath, one per sequencer step
  typedef struct packed {
    logic clear;   // zero one store entry, advance the sweep address
    logic accept;  // capture request, form position minus offset
    logic absval;  // take magnitude and sign of each difference
    logic load;    // load the three dividers
    logic step;    // one quotient bit in each divider
    logic check;   // bounds check, first products of the linear index
    logic lin;     // finish the linear index
    logic read;    // read the store entry
    logic write;   // update the entry and register the result
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/vog_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per step, MSB first.
module vog_divider #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 17
) (
  input  wire              clk,
  input  wire              load,
  input  wire              step,
  input  wire [NUM_W-1:0]  numer,
  input  wire [DEN_W-1:0]  denom,
  output logic [NUM_W-1:0] quot
);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   trial;
  logic             qbit;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (load) begin
      num_sh <= numer;
      rem    <= '0;
      den    <= denom;
      quot   <= '0;
    end else if (step) begin
      num_sh <= num_sh << 1;
      rem    <= qbit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quot   <= {quot[NUM_W-2:0], qbit};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/vog_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vog_datapath #(
  parameter int MAX_X     = 64,
  parameter int MAX_Y     = 64,
  parameter int MAX_Z     = 16,
  parameter int POS_WIDTH = 24,
  parameter int CFG_W     = 24,
  parameter int NUM_W     = 26
) (
  input  wire                           clk,
  input  wire                           rst,
  input  vog_pkg::cmd_t                 cmd,
  output logic                          clear_last,
  input  wire                           cfg_valid,
  input  wire [vog_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_W-1:0]               cfg_data,
  input  wire                           req_type,
  input  wire [POS_WIDTH-1:0]           pos_x,
  input  wire [POS_WIDTH-1:0]           pos_y,
  input  wire [POS_WIDTH-1:0]           pos_z,
  input  wire [1:0]                     write_value,
  output logic                          done,
  output logic [1:0]                    occupancy,
  output logic                          out_of_bounds,
  output logic                          written
);

  localparam int PW     = POS_WIDTH;
  localparam int RES_W  = vog_pkg::RES_W;
  localparam int DEN_W  = RES_W + 1;
  localparam int DEPTH  = MAX_X * MAX_Y * MAX_Z;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IX_W   = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int IY_W   = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int IZ_W   = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int SZX_W  = ($clog2(MAX_X + 1) > vog_pkg::SIZE_XY_W) ?
                          $clog2(MAX_X + 1) : vog_pkg::SIZE_XY_W;
  localparam int SZY_W  = ($clog2(MAX_Y + 1) > vog_pkg::SIZE_XY_W) ?
                          $clog2(MAX_Y + 1) : vog_pkg::SIZE_XY_W;
  localparam int SZZ_W  = ($clog2(MAX_Z + 1) > vog_pkg::SIZE_Z_W) ?
                          $clog2(MAX_Z + 1) : vog_pkg::SIZE_Z_W;
  localparam int IYSX_W = IY_W + SZX_W;
  localparam int SXSY_W = SZX_W + SZY_W;
  localparam int LIN_W  = IZ_W + SZX_W + SZY_W + 1;

  // Configuration registers
  logic [RES_W-1:0] resolution;
  logic [PW-1:0]    offset [3];
  logic [SZX_W-1:0] size_x;
  logic [SZY_W-1:0] size_y;
  logic [SZZ_W-1:0] size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= RES_W'(16);
      offset[0]  <= '0;
      offset[1]  <= '0;
      offset[2]  <= '0;
      size_x     <= SZX_W'(MAX_X);
      size_y     <= SZY_W'(MAX_Y);
      size_z     <= SZZ_W'(MAX_Z);
    end else if (cfg_valid) begin
      case (cfg_index)
        vog_pkg::REG_RESOLUTION: resolution <= cfg_data[RES_W-1:0];
        vog_pkg::REG_OFFSET_X:   offset[0]  <= cfg_data[PW-1:0];
        vog_pkg::REG_OFFSET_Y:   offset[1]  <= cfg_data[PW-1:0];
        vog_pkg::REG_OFFSET_Z:   offset[2]  <= cfg_data[PW-1:0];
        vog_pkg::REG_SIZE_X:     size_x <= SZX_W'(cfg_data[vog_pkg::SIZE_XY_W-1:0]);
        vog_pkg::REG_SIZE_Y:     size_y <= SZY_W'(cfg_data[vog_pkg::SIZE_XY_W-1:0]);
        vog_pkg::REG_SIZE_Z:     size_z <= SZZ_W'(cfg_data[vog_pkg::SIZE_Z_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sizes above the built grid saturate to it
  logic [SZX_W-1:0] sx;
  logic [SZY_W-1:0] sy;
  logic [SZZ_W-1:0] sz;
  assign sx = (32'(size_x) > MAX_X) ? SZX_W'(MAX_X) : size_x;
  assign sy = (32'(size_y) > MAX_Y) ? SZY_W'(MAX_Y) : size_y;
  assign sz = (32'(size_z) > MAX_Z) ? SZZ_W'(MAX_Z) : size_z;

  // Request capture and difference
  logic          req;
  logic [1:0]    wval;
  logic [PW:0]   diff [3];
  logic [PW-1:0] pos  [3];
  logic [PW-1:0] mag  [3];
  logic          neg  [3];

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req  <= req_type;
      wval <= write_value;
      for (int i = 0; i < 3; i++) begin
        diff[i] <= {pos[i][PW-1], pos[i]} - {offset[i][PW-1], offset[i]};
      end
    end
    if (cmd.absval) begin
      for (int i = 0; i < 3; i++) begin
        neg[i] <= diff[i][PW];
        mag[i] <= diff[i][PW] ? PW'(-diff[i]) : diff[i][PW-1:0];
      end
    end
  end

  // Rounded quotient (2|d| + r) / (2r) on each axis
  logic [NUM_W-1:0] numer [3];
  logic [NUM_W-1:0] quot  [3];
  logic [DEN_W-1:0] denom;

  assign denom = {resolution, 1'b0};

  for (genvar g = 0; g < 3; g++) begin : g_axis
    assign numer[g] = NUM_W'({mag[g], 1'b0}) + NUM_W'(resolution);

    vog_divider #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
    ) u_div (
      .clk  (clk),
      .load (cmd.load),
      .step (cmd.step),
      .numer(numer[g]),
      .denom(denom),
      .quot (quot[g])
    );
  end

  // Bounds check and linear index
  logic              inb;
  logic              ok_x, ok_y, ok_z;
  logic [IX_W-1:0]   ix;
  logic [IZ_W-1:0]   iz;
  logic [IYSX_W-1:0] iysx;
  logic [SXSY_W-1:0] sxsy;
  logic [LIN_W-1:0]  lin_sum;
  logic [AW-1:0]     lin;

  assign ok_x = !(neg[0] && quot[0] != '0) && (quot[0] < NUM_W'(sx));
  assign ok_y = !(neg[1] && quot[1] != '0) && (quot[1] < NUM_W'(sy));
  assign ok_z = !(neg[2] && quot[2] != '0) && (quot[2] < NUM_W'(sz));

  assign lin_sum = LIN_W'(ix) + LIN_W'(iysx) + LIN_W'(iz) * LIN_W'(sxsy);

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      inb  <= (resolution != '0) && ok_x && ok_y && ok_z;
      ix   <= quot[0][IX_W-1:0];
      iz   <= quot[2][IZ_W-1:0];
      iysx <= IYSX_W'(quot[1][IY_W-1:0]) * IYSX_W'(sx);
      sxsy <= SXSY_W'(sx) * SXSY_W'(sy);
    end
    if (cmd.lin) begin
      lin <= lin_sum[AW-1:0];
    end
  end

  // Voxel store
  logic [1:0]    mem [DEPTH];
  logic [1:0]    rd_data;
  logic [AW-1:0] clr_addr;
  logic          do_write;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_data;

  assign clear_last = (clr_addr == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign do_write = inb && (req == vog_pkg::REQ_WRITE) && (wval != vog_pkg::OCC_OOB)
                    && !(wval == vog_pkg::OCC_EMPTY && rd_data == vog_pkg::OCC_OCCUPIED)
                    && (wval != rd_data);

  assign wr_en   = cmd.clear || (cmd.write && do_write);
  assign wr_addr = cmd.clear ? clr_addr : lin;
  assign wr_data = cmd.clear ? vog_pkg::OCC_UNMAPPED : wval;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= mem[lin];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.write;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      occupancy     <= inb ? rd_data : vog_pkg::OCC_OOB;
      out_of_bounds <= !inb;
      written       <= do_write;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/vog_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vog_ctrl #(
  parameter int NUM_W = 26
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           start,
  input  wire           clear_last,
  output logic          busy,
  output vog_pkg::cmd_t cmd
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_ABS   = 9'b000000100,
    ST_LOAD  = 9'b000001000,
    ST_DIV   = 9'b000010000,
    ST_CHECK = 9'b000100000,
    ST_LIN   = 9'b001000000,
    ST_READ  = 9'b010000000,
    ST_WRITE = 9'b100000000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] step_cnt;
  logic             last_step;

  assign last_step = (step_cnt == CNT_W'(NUM_W - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clear_last) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_ABS;
      ST_ABS:   state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV:   if (last_step) state_next = ST_CHECK;
      ST_CHECK: state_next = ST_LIN;
      ST_LIN:   state_next = ST_READ;
      ST_READ:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD) begin
        step_cnt <= '0;
      end else if (state == ST_DIV) begin
        step_cnt <= step_cnt + CNT_W'(1);
      end
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.clear  = (state == ST_CLEAR);
    cmd.accept = (state == ST_IDLE) && start;
    cmd.absval = (state == ST_ABS);
    cmd.load   = (state == ST_LOAD);
    cmd.step   = (state == ST_DIV);
    cmd.check  = (state == ST_CHECK);
    cmd.lin    = (state == ST_LIN);
    cmd.read   = (state == ST_READ);
    cmd.write  = (state == ST_WRITE);
  end

endmodule

`default_nettype wire

// ----- rtl/core/voxel_occupancy_grid_access.sv -----
// One request at a time: start is taken only while busy is low. The restoring dividers take
// one quotient bit per cycle.
// Reset: synchronous; resets the config registers, then zeroes the store one entry per cycle,
// all MAX_X*MAX_Y*MAX_Z entries (65536 by default), with busy high; config writes still land.
// Each result is presented for exactly one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module voxel_occupancy_grid_access #(
  parameter int MAX_X     = 64,
  parameter int MAX_Y     = 64,
  parameter int MAX_Z     = 16,
  parameter int POS_WIDTH = 24
) (
  input  wire                           clk,
  input  wire                           rst,
  // Request channel
  input  wire                           start,
  output logic                          busy,
  input  wire                           req_type,
  input  wire [POS_WIDTH-1:0]           pos_x,
  input  wire [POS_WIDTH-1:0]           pos_y,
  input  wire [POS_WIDTH-1:0]           pos_z,
  input  wire [1:0]                     write_value,
  // Result strobe and fields
  output logic                          done,
  output logic [1:0]                    occupancy,
  output logic                          out_of_bounds,
  output logic                          written,
  // Configuration write channel
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [vog_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [((POS_WIDTH > vog_pkg::RES_W) ? POS_WIDTH : vog_pkg::RES_W)-1:0] cfg_data
);

  // Config data carries the widest register: an offset or the resolution
  localparam int CFG_W = (POS_WIDTH > vog_pkg::RES_W) ? POS_WIDTH : vog_pkg::RES_W;

  // Dividend 2|d| + r spans one bit more than the wider of |d| shifted and r
  localparam int NUM_W = ((POS_WIDTH + 1 > vog_pkg::RES_W) ?
                          POS_WIDTH + 1 : vog_pkg::RES_W) + 1;

  vog_pkg::cmd_t cmd;
  logic          clear_last;

  // Registers take a write in any cycle, even during the store clear
  assign cfg_ready = 1'b1;

  // Sequencer: clear sweep, then one request at a time through the datapath
  vog_ctrl #(
    .NUM_W(NUM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .clear_last(clear_last),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Quantize, bounds check, linearize x-fastest, read-modify-write the store
  vog_datapath #(
    .MAX_X    (MAX_X),
    .MAX_Y    (MAX_Y),
    .MAX_Z    (MAX_Z),
    .POS_WIDTH(POS_WIDTH),
    .CFG_W    (CFG_W),
    .NUM_W    (NUM_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .clear_last   (clear_last),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .write_value  (write_value),
    .done         (done),
    .occupancy    (occupancy),
    .out_of_bounds(out_of_bounds),
    .written      (written)
  );

endmodule

`default_nettype wire

// ----- tb/voxel_occupancy_grid_access_tb.sv -----
`timescale 1ns / 1ps

module voxel_occupancy_grid_access_tb;
  import vog_pkg::*;

  localparam int POS_W        = 24;
  localparam int CFG_W        = (POS_W > RES_W) ? POS_W : RES_W;
  localparam int GRID_X       = 64;
  localparam int GRID_Y       = 64;
  localparam int GRID_Z       = 16;
  localparam int GRID_CELLS   = GRID_X * GRID_Y * GRID_Z;
  localparam int SETTLE       = 40;
  localparam int RANDOM_ITEMS = 1930;

  typedef struct packed {
    logic             req_type;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [1:0]       write_value;
  } grid_req_t;

  typedef struct packed {
    logic [1:0] occupancy;
    logic       out_of_bounds;
    logic       written;
  } grid_rsp_t;

  // Every input starts at a known value; rst starts high until the stimulus lowers it.
  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 start       = 1'b0;
  logic                 req_type    = REQ_READ;
  logic [POS_W-1:0]     pos_x       = '0;
  logic [POS_W-1:0]     pos_y       = '0;
  logic [POS_W-1:0]     pos_z       = '0;
  logic [1:0]           write_value = OCC_UNMAPPED;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = REG_RESOLUTION;
  logic [CFG_W-1:0]     cfg_data    = '0;

  wire       busy;
  wire       done;
  wire [1:0] occupancy;
  wire       out_of_bounds;
  wire       written;
  wire       cfg_ready;

  voxel_occupancy_grid_access #(
    .MAX_X     (GRID_X),
    .MAX_Y     (GRID_Y),
    .MAX_Z     (GRID_Z),
    .POS_WIDTH (POS_W)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .write_value   (write_value),
    .done          (done),
    .occupancy     (occupancy),
    .out_of_bounds (out_of_bounds),
    .written       (written),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the grid: the store and the register file as the block
  // should hold them. The store starts all unmapped, like the clearing pass.
  bit [1:0]                voxel_model [GRID_CELLS];
  logic [RES_W-1:0]        res_q    = 16;
  logic signed [POS_W-1:0] off_x_q  = '0;
  logic signed [POS_W-1:0] off_y_q  = '0;
  logic signed [POS_W-1:0] off_z_q  = '0;
  logic [SIZE_XY_W-1:0]    size_x_q = GRID_X;
  logic [SIZE_XY_W-1:0]    size_y_q = GRID_Y;
  logic [SIZE_Z_W-1:0]     size_z_q = GRID_Z;

  grid_req_t   req_pending[$];   // requests waiting for their start transfer
  grid_rsp_t   occ_expected[$];  // predicted results, oldest first
  int unsigned idle_left   = 0;
  int unsigned burst_left  = 0;
  int unsigned mismatches  = 0;
  int unsigned random_sent = 0;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // Quantize one axis: |pos - offset| / res rounded half away from zero.
  // A negative difference only lands in the grid when it rounds to index 0.
  function automatic bit axis_index(input logic signed [POS_W-1:0] p,
                                    input logic signed [POS_W-1:0] o,
                                    input int unsigned lim, output longint idx);
    longint d;
    longint a;
    d   = longint'(p) - longint'(o);
    a   = (d < 0) ? -d : d;
    idx = (2 * a + longint'(res_q)) / (2 * longint'(res_q));
    return !(d < 0 && idx != 0) && idx < lim;
  endfunction

  // Work out the result of one request and apply its write to the shadow store.
  function automatic grid_rsp_t grid_predict(input grid_req_t r);
    grid_rsp_t   e;
    longint      ix;
    longint      iy;
    longint      iz;
    int unsigned sx;
    int unsigned sy;
    int unsigned sz;
    int unsigned slot;
    bit          inb;
    sx = clamp_dim(size_x_q, GRID_X);
    sy = clamp_dim(size_y_q, GRID_Y);
    sz = clamp_dim(size_z_q, GRID_Z);
    e.occupancy     = OCC_OOB;
    e.out_of_bounds = 1'b1;
    e.written       = 1'b0;
    // Zero resolution puts everything out of bounds; a zero size does the
    // same through the bounds check itself.
    inb = (res_q != 0);
    if (inb) begin
      inb = axis_index(r.pos_x, off_x_q, sx, ix)
         && axis_index(r.pos_y, off_y_q, sy, iy)
         && axis_index(r.pos_z, off_z_q, sz, iz);
    end
    if (inb) begin
      slot            = ix + iy * sx + iz * sx * sy;
      e.occupancy     = voxel_model[slot];
      e.out_of_bounds = 1'b0;
      // Drop writes of code three, of the value already held, and of empty
      // over occupied.
      if (r.req_type == REQ_WRITE && r.write_value != OCC_OOB
          && !(r.write_value == OCC_EMPTY && e.occupancy == OCC_OCCUPIED)
          && r.write_value != e.occupancy) begin
        voxel_model[slot] = r.write_value;
        e.written         = 1'b1;
      end
    end
    return e;
  endfunction

  // Position that quantizes near voxel i of one axis; stray pushes it one
  // voxel past either end. The jitter covers both sides of each rounding edge.
  function automatic logic [POS_W-1:0] axis_pos(input logic signed [POS_W-1:0] o,
                                                input int unsigned lim, input bit stray);
    longint i;
    longint j;
    longint p;
    if (stray) i = $urandom_range(0, 1) ? longint'(lim) : -1;
    else i = (lim == 0) ? 0 : longint'($urandom_range(0, lim - 1));
    j = longint'($urandom_range(0, res_q)) - longint'(res_q / 2);
    p = longint'(o) + i * longint'(res_q) + j;
    return p[POS_W-1:0];
  endfunction

  // Put random bits above a narrow register now and then; the block keeps
  // only the low bits.
  function automatic logic [CFG_W-1:0] with_junk(input int unsigned v, input int w);
    logic [CFG_W-1:0] d;
    d = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom) : '0;
    for (int b = 0; b < w; b++) d[b] = v[b];
    return d;
  endfunction

  function automatic int pick_offset();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return int'($urandom_range(0, 40000)) - 20000;
    if (roll < 17) return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
    return roll[0] ? 8388607 : -8388608;
  endfunction

  function automatic int unsigned pick_res();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return $urandom_range(1, 4);
    if (roll < 7) return $urandom_range(5, 64);
    if (roll < 9) return $urandom_range(65, 2000);
    return $urandom_range(2001, 65535);
  endfunction

  // Idle cycles after a request: mostly none or short, a few long, and now
  // and then a burst of back-to-back requests.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    if (roll < 4) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 38) return 0;
    if (roll < 80) return $urandom_range(1, 40);
    if (roll < 95) return $urandom_range(41, 90);
    return $urandom_range(91, 120);
  endfunction

  task automatic push_req(input logic rt, input int x, input int y, input int z,
                          input logic [1:0] wv);
    grid_req_t r;
    r.req_type    = rt;
    r.pos_x       = POS_W'(x);
    r.pos_y       = POS_W'(y);
    r.pos_z       = POS_W'(z);
    r.write_value = wv;
    req_pending.push_back(r);
  endtask

  // Mostly requests that land inside the configured grid with random
  // content; the rest are stray axes and fully random positions.
  task automatic push_random_req();
    grid_req_t   r;
    int unsigned roll;
    logic [2:0]  stray;
    roll          = $urandom_range(0, 99);
    r.req_type    = $urandom_range(0, 1);
    r.write_value = $urandom_range(0, 3);
    if (roll < 8) begin
      r.pos_x = POS_W'($urandom);
      r.pos_y = POS_W'($urandom);
      r.pos_z = POS_W'($urandom);
    end else begin
      stray   = (roll < 18) ? 3'($urandom_range(1, 7)) : 3'd0;
      r.pos_x = axis_pos(off_x_q, clamp_dim(size_x_q, GRID_X), stray[0]);
      r.pos_y = axis_pos(off_y_q, clamp_dim(size_y_q, GRID_Y), stray[1]);
      r.pos_z = axis_pos(off_z_q, clamp_dim(size_z_q, GRID_Z), stray[2]);
    end
    req_pending.push_back(r);
  endtask

  // Call right after a rising edge. Hold valid until the transfer, then
  // update the shadow register. The caller lowers valid after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RESOLUTION: res_q    = data[RES_W-1:0];
      REG_OFFSET_X:   off_x_q  = data[POS_W-1:0];
      REG_OFFSET_Y:   off_y_q  = data[POS_W-1:0];
      REG_OFFSET_Z:   off_z_q  = data[POS_W-1:0];
      REG_SIZE_X:     size_x_q = data[SIZE_XY_W-1:0];
      REG_SIZE_Y:     size_y_q = data[SIZE_XY_W-1:0];
      REG_SIZE_Z:     size_z_q = data[SIZE_Z_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input int unsigned res, input int ox, input int oy, input int oz,
                          input int unsigned sx, input int unsigned sy,
                          input int unsigned sz);
    write_reg(REG_RESOLUTION, with_junk(res, RES_W));
    write_reg(REG_OFFSET_X, CFG_W'(ox));
    write_reg(REG_OFFSET_Y, CFG_W'(oy));
    write_reg(REG_OFFSET_Z, CFG_W'(oz));
    write_reg(REG_SIZE_X, with_junk(sx, SIZE_XY_W));
    write_reg(REG_SIZE_Y, with_junk(sy, SIZE_XY_W));
    write_reg(REG_SIZE_Z, with_junk(sz, SIZE_Z_W));
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued request has had its start transfer and every
  // result has come back, then let the block settle.
  task automatic drain();
    do @(posedge clk); while (req_pending.size() != 0 || start || occ_expected.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Request driver. A start transfer happens at an edge where start is high
  // and busy is low; predict the result right there, so the shadow store
  // sees requests in the order the block takes them. Keep start high across
  // back-to-back requests, otherwise count down the idle gap.
  always @(posedge clk) begin : drive_requests
    grid_req_t nxt;
    if (rst) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        occ_expected.push_back(grid_predict({req_type, pos_x, pos_y, pos_z, write_value}));
      end
      if (!start || !busy) begin
        if (idle_left != 0) begin
          start     <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (req_pending.size() != 0) begin
          nxt          = req_pending.pop_front();
          start       <= 1'b1;
          req_type    <= nxt.req_type;
          pos_x       <= nxt.pos_x;
          pos_y       <= nxt.pos_y;
          pos_z       <= nxt.pos_z;
          write_value <= nxt.write_value;
          idle_left   <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor. The strobe lasts one cycle and cannot be held off, so
  // take every result at the edge that ends its cycle and match it against
  // the oldest prediction.
  always @(posedge clk) begin : check_results
    grid_rsp_t want;
    if (!rst && done) begin
      if (occ_expected.size() == 0) begin
        $error("unexpected result: occupancy %0d out_of_bounds %0d written %0d",
               occupancy, out_of_bounds, written);
        mismatches++;
      end else begin
        want = occ_expected.pop_front();
        if (occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
          mismatches++;
        end
        if (out_of_bounds !== want.out_of_bounds) begin
          $error("out_of_bounds: expected %0d, got %0d", want.out_of_bounds, out_of_bounds);
          mismatches++;
        end
        if (written !== want.written) begin
          $error("written: expected %0d, got %0d", want.written, written);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    int unsigned kind;
    int unsigned res;
    int unsigned sx;
    int unsigned sy;
    int unsigned sz;
    int          ox;
    int          oy;
    int          oz;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset settings: 16 per voxel, origin at zero,
    // full 64 x 64 x 16 grid. The driver holds off until the clearing pass
    // drops busy.
    push_req(REQ_READ,  0, 0, 0, OCC_UNMAPPED);
    push_req(REQ_WRITE, 0, 0, 0, OCC_OCCUPIED);
    push_req(REQ_WRITE, 0, 0, 0, OCC_EMPTY);       // empty must not replace occupied
    push_req(REQ_WRITE, 0, 0, 0, OCC_OCCUPIED);    // same value again, no change
    push_req(REQ_WRITE, 16, 0, 0, OCC_OOB);        // code three is dropped
    push_req(REQ_WRITE, 16, 0, 0, OCC_EMPTY);
    push_req(REQ_WRITE, 16, 0, 0, OCC_UNMAPPED);
    push_req(REQ_WRITE, 8, 8, 8, OCC_OCCUPIED);    // exact half rounds up to voxel 1
    push_req(REQ_READ,  16, 16, 16, OCC_UNMAPPED);
    push_req(REQ_READ,  7, -7, 0, OCC_UNMAPPED);   // small negative rounds to voxel 0
    push_req(REQ_READ,  -8, 0, 0, OCC_UNMAPPED);   // negative half rounds out of the grid
    push_req(REQ_WRITE, 1008, 1008, 240, OCC_OCCUPIED);
    push_req(REQ_READ,  1015, 1015, 247, OCC_UNMAPPED);
    push_req(REQ_WRITE, 1016, 0, 0, OCC_OCCUPIED); // one past the far x edge
    push_req(REQ_READ,  8388607, -8388608, -1, OCC_UNMAPPED);
    push_req(REQ_WRITE, -8388608, 8388607, 0, OCC_EMPTY);
    push_req(REQ_READ,  0, 0, 256, OCC_UNMAPPED);
    drain();

    // Zero resolution: everything is out of bounds.
    set_grid(0, 0, 0, 0, GRID_X, GRID_Y, GRID_Z);
    push_req(REQ_READ,  0, 0, 0, OCC_UNMAPPED);
    push_req(REQ_WRITE, 16, 16, 16, OCC_OCCUPIED);
    drain();

    // Zero sizes: everything is out of bounds.
    set_grid(16, 0, 0, 0, 0, 0, 0);
    push_req(REQ_READ,  0, 0, 0, OCC_UNMAPPED);
    push_req(REQ_WRITE, 0, 0, 0, OCC_UNMAPPED);
    drain();

    // Sizes above the maximum saturate to the full grid.
    set_grid(16, 0, 0, 0, 127, 100, 31);
    push_req(REQ_WRITE, 992, 16, 240, OCC_EMPTY);
    push_req(REQ_READ,  992, 16, 240, OCC_UNMAPPED);
    push_req(REQ_READ,  1024, 0, 0, OCC_UNMAPPED);
    drain();

    // Random phases. The first two pin the register extremes; after that,
    // mostly small grids so reads come back to cells written earlier.
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 19);
      res  = pick_res();
      ox   = pick_offset();
      oy   = pick_offset();
      oz   = pick_offset();
      sx   = $urandom_range(1, 6);
      sy   = $urandom_range(1, 6);
      sz   = $urandom_range(1, 4);
      if (phase == 0) begin
        res = 1;
        ox  = 8388607;
        oy  = 8388607;
        oz  = 8388607;
        sx  = 1;
        sy  = 1;
        sz  = 1;
      end else if (phase == 1) begin
        res = 65535;
        ox  = -8388608;
        oy  = -8388608;
        oz  = -8388608;
        sx  = GRID_X;
        sy  = GRID_Y;
        sz  = GRID_Z;
      end else if (kind == 0) begin
        res = 0;
      end else if (kind == 1) begin
        case ($urandom_range(0, 2))
          0: sx = 0;
          1: sy = 0;
          default: sz = 0;
        endcase
      end else if (kind == 2) begin
        sx = $urandom_range(GRID_X + 1, 127);
        sy = $urandom_range(GRID_Y + 1, 127);
        sz = $urandom_range(GRID_Z + 1, 31);
      end else if (kind < 7) begin
        sx = GRID_X;
        sy = GRID_Y;
        sz = GRID_Z;
      end
      set_grid(res, ox, oy, oz, sx, sy, sz);
      n = $urandom_range(40, 160);
      repeat (n) push_random_req();
      random_sent += n;
      drain();
      phase++;
    end

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Hard stop: far beyond the slowest legal run, clearing pass included.
  initial begin : watchdog
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- voxel_occupancy_grid_access.f -----
rtl/core/vog_pkg.sv
rtl/core/vog_divider.sv
rtl/core/vog_datapath.sv
rtl/core/vog_ctrl.sv
rtl/core/voxel_occupancy_grid_access.sv
tb/voxel_occupancy_grid_access_tb.sv
